/* hw/rtl/srrip_pkg.sv */
package srrip_pkg;

  typedef enum logic [1:0] {
    CMD_HIT    = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_VICTIM = 2'd3
  } cmd_e;

  localparam int unsigned CtrW     = 8;
  localparam int unsigned WayIdxW  = 5;
  localparam logic [3:0]  CbitsRst = 4'd2;
  localparam logic [7:0]  CtrRst   = 8'd3;

  typedef struct packed {
    logic               has_empty;
    logic [WayIdxW-1:0] empty_way;
    logic [WayIdxW-1:0] max_way;
    logic [CtrW-1:0]    max_val;
  } vsel_t;

  function automatic logic [CtrW-1:0] ceiling(input logic [3:0] bits);
    logic [3:0] b;
    b = bits;
    if (b < 4'd1) b = 4'd1;
    if (b > 4'd8) b = 4'd8;
    return CtrW'((9'd1 << b) - 9'd1);
  endfunction

endpackage

/* hw/rtl/srrip_replacement_policy.sv */
// hit, insert, invalidate: the set row is read at the transfer and written back in ST_READ
// victim request: the row is read, the victim picked in ST_READ and registered in ST_FIN
// each item is a read-modify-write of one set row; input stalls until it is done, and ST_FIN waits on out_stall_i
// an item with set or way out of range is dropped at the transfer (way unchecked for victim)
// after reset a clearing pass writes all SETS rows, one per cycle, input stalled meanwhile
// rows clear to invalid lines with counters at 3, counter_bits resets to 2
module srrip_replacement_policy #(
  parameter int WAYS = 8,
  parameter int SETS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [5:0] set_index_i,
  input  logic [2:0] way_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] victim_way_o,
  output logic       victim_was_empty_o
);

  localparam int CW    = srrip_pkg::CtrW;
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * (CW + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FIN
  } state_e;

  state_e             state_q;
  logic [SET_W-1:0]   clr_q;
  logic [3:0]         cbits_q;
  logic [1:0]         cmd_q;
  logic [SET_W-1:0]   set_q;
  logic [WAY_W-1:0]   way_q;
  logic [ROW_W-1:0]   row_q;
  logic [2:0]         pick_q;
  logic               empty_q;
  logic [CW-1:0]      top_q;
  logic               out_valid_q;
  logic [2:0]         victim_way_q;
  logic               victim_empty_q;

  logic               accept;
  logic               in_range;
  logic               go;
  logic               age;
  logic [CW-1:0]      ceil_m;
  logic [CW-1:0]      add;
  logic               mem_we;
  logic               mem_re;
  logic [SET_W-1:0]   mem_waddr;
  logic [ROW_W-1:0]   mem_wdata;
  logic [ROW_W-1:0]   mem_rdata;
  logic [ROW_W-1:0]   row_mod;
  logic [ROW_W-1:0]   row_age;
  logic [ROW_W-1:0]   row_clr;
  srrip_pkg::vsel_t   vsel;

  assign ceil_m     = srrip_pkg::ceiling(cbits_q);
  assign add        = ceil_m - top_q;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(set_index_i) < SETS) &&
                      ((command_i == srrip_pkg::CMD_VICTIM) || (32'(way_i) < WAYS));
  assign mem_re     = accept && in_range;
  assign go         = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign age        = !empty_q && (top_q < ceil_m);

  srrip_state_mem #(
    .ROW_W  (ROW_W),
    .SETS   (SETS),
    .ADDR_W (SET_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (SET_W'(set_index_i)),
    .rdata_o (mem_rdata)
  );

  srrip_victim_sel #(
    .WAYS (WAYS)
  ) u_vsel (
    .valid_i (mem_rdata[WAYS-1:0]),
    .ctr_i   (mem_rdata[ROW_W-1:WAYS]),
    .sel_o   (vsel)
  );

  always_comb begin
    row_clr = '0;
    for (int w = 0; w < WAYS; w++) begin
      row_clr[WAYS + CW*w +: CW] = srrip_pkg::CtrRst;
    end

    row_mod = mem_rdata;
    case (cmd_q)
      srrip_pkg::CMD_HIT: begin
        row_mod[WAYS + CW*way_q +: CW] = '0;
      end
      srrip_pkg::CMD_INSERT: begin
        row_mod[WAYS + CW*way_q +: CW] = ceil_m - CW'(1);
        row_mod[way_q]                 = 1'b1;
      end
      srrip_pkg::CMD_INVAL: begin
        row_mod[WAYS + CW*way_q +: CW] = ceil_m;
        row_mod[way_q]                 = 1'b0;
      end
      default: begin
        row_mod = mem_rdata;
      end
    endcase

    row_age = row_q;
    for (int w = 0; w < WAYS; w++) begin
      row_age[WAYS + CW*w +: CW] = row_q[WAYS + CW*w +: CW] + add;
    end

    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = row_mod;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = row_clr;
      end
      ST_READ: begin
        mem_we = (cmd_q != srrip_pkg::CMD_VICTIM);
      end
      ST_FIN: begin
        mem_we    = go && age;
        mem_wdata = row_age;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      cbits_q        <= srrip_pkg::CbitsRst;
      out_valid_q    <= 1'b0;
      cmd_q          <= '0;
      set_q          <= '0;
      way_q          <= '0;
      row_q          <= '0;
      pick_q         <= '0;
      empty_q        <= 1'b0;
      top_q          <= '0;
      victim_way_q   <= '0;
      victim_empty_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cbits_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && !go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + SET_W'(1);
          if (clr_q == SET_W'(SETS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (mem_re) begin
            cmd_q   <= command_i;
            set_q   <= SET_W'(set_index_i);
            way_q   <= WAY_W'(way_i);
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (cmd_q == srrip_pkg::CMD_VICTIM) begin
            row_q   <= mem_rdata;
            empty_q <= vsel.has_empty;
            pick_q  <= vsel.has_empty ? vsel.empty_way[2:0] : vsel.max_way[2:0];
            top_q   <= vsel.max_val;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_FIN: begin
          if (go) begin
            out_valid_q    <= 1'b1;
            victim_way_q   <= pick_q;
            victim_empty_q <= empty_q;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign victim_way_o       = victim_way_q;
  assign victim_was_empty_o = victim_empty_q;

  // result only appears after the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result without finish step");

  // no input transfer during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("input taken during clear");

  // read and write never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write collide");

  // clearing pass covers every row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == ST_CLEAR) |-> ($past(clr_q) == SET_W'(SETS - 1)))
    else $error("clearing pass ended early");

endmodule

/* hw/rtl/srrip_state_mem.sv */
module srrip_state_mem #(
  parameter int ROW_W  = 72,
  parameter int SETS   = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ROW_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [ROW_W-1:0]  rdata_o
);

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/srrip_victim_sel.sv */
module srrip_victim_sel #(
  parameter int WAYS = 8
) (
  input  logic [WAYS-1:0]                   valid_i,
  input  logic [WAYS*srrip_pkg::CtrW-1:0]   ctr_i,
  output srrip_pkg::vsel_t                  sel_o
);

  localparam int LVL = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int N   = 1 << LVL;

  logic [srrip_pkg::CtrW-1:0]    tv [LVL+1][N];
  logic [srrip_pkg::WayIdxW-1:0] ti [LVL+1][N];

  always_comb begin
    // first invalid way
    sel_o.has_empty = 1'b0;
    sel_o.empty_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!valid_i[w]) begin
        sel_o.has_empty = 1'b1;
        sel_o.empty_way = srrip_pkg::WayIdxW'(w);
      end
    end

    // max tree, ties go to the lower way
    for (int l = 0; l <= LVL; l++) begin
      for (int i = 0; i < N; i++) begin
        tv[l][i] = '0;
        ti[l][i] = '0;
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      tv[0][i] = ctr_i[srrip_pkg::CtrW*i +: srrip_pkg::CtrW];
      ti[0][i] = srrip_pkg::WayIdxW'(i);
    end
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < (N >> (l + 1)); i++) begin
        if (tv[l][2*i] >= tv[l][2*i+1]) begin
          tv[l+1][i] = tv[l][2*i];
          ti[l+1][i] = ti[l][2*i];
        end else begin
          tv[l+1][i] = tv[l][2*i+1];
          ti[l+1][i] = ti[l][2*i+1];
        end
      end
    end
    sel_o.max_val = tv[LVL][0];
    sel_o.max_way = ti[LVL][0];
  end

endmodule
